@@ rtl/prq_pkg.sv @@
// Package for the priority ready-queue scheduler.
// Request codes, config register indexes, chain control and FSM types.
// No dependencies.
package prq_pkg;

  localparam int PRI_W = 6;
  localparam int REQ_W = 3;
  localparam int CFG_W = 8;

  localparam logic [REQ_W-1:0] REQ_TICK    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_UNBLOCK = 3'd1;
  localparam logic [REQ_W-1:0] REQ_YIELD   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_BLOCK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_SETPRI  = 3'd4;

  localparam logic CFG_SLICE_LIMIT = 1'b0;
  localparam logic CFG_IDLE_ID     = 1'b1;

  localparam logic [CFG_W-1:0] SLICE_LIMIT_RST = 8'd4;
  localparam logic [CFG_W-1:0] IDLE_ID_RST     = 8'd0;
  localparam logic [CFG_W-1:0] SLICE_MAX       = 8'd255;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INSERT,
    OP_POP
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [PRI_W-1:0] pri;
  } chain_ctrl_t;

  typedef enum logic {
    ST_IDLE,
    ST_DISPATCH
  } state_t;

endpackage

@@ rtl/prq_cell.sv @@
// One slot of the ready-queue chain: holds an id and a priority.
// Shifts toward the back on insert, toward the front on pop. Uses prq_pkg.
module prq_cell
  import prq_pkg::*;
#(
  parameter int ID_BITS = 8
) (
  input  logic               clk,
  input  chain_ctrl_t        ctrl,
  input  logic [ID_BITS-1:0] new_id,
  input  logic               valid,
  input  logic               prev_ge,
  input  logic [ID_BITS-1:0] prev_id,
  input  logic [PRI_W-1:0]   prev_pri,
  input  logic [ID_BITS-1:0] next_id,
  input  logic [PRI_W-1:0]   next_pri,
  output logic               ge,
  output logic [ID_BITS-1:0] id,
  output logic [PRI_W-1:0]   pri
);

  // stays ahead of the new item: equal priority keeps arrival order
  assign ge = valid && (pri >= ctrl.pri);

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_INSERT: begin
        if (!ge) begin
          if (prev_ge) begin
            id  <= new_id;
            pri <= ctrl.pri;
          end else begin
            id  <= prev_id;
            pri <= prev_pri;
          end
        end
      end
      OP_POP: begin
        id  <= next_id;
        pri <= next_pri;
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/prq_chain.sv @@
// Ready queue as a row of prq_cell slots, front at slot 0.
// Depends on prq_pkg and prq_cell.
module prq_chain
  import prq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64,
  parameter int ID_BITS     = 8,
  parameter int CNT_W       = 7
) (
  input  logic               clk,
  input  chain_ctrl_t        ctrl,
  input  logic [ID_BITS-1:0] new_id,
  input  logic [CNT_W-1:0]   size,
  output logic [ID_BITS-1:0] front_id,
  output logic [PRI_W-1:0]   front_pri
);

  logic [ID_BITS-1:0] id_w  [QUEUE_DEPTH];
  logic [PRI_W-1:0]   pri_w [QUEUE_DEPTH];
  logic               ge_w  [QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic               valid;
    logic               p_ge;
    logic [ID_BITS-1:0] p_id;
    logic [PRI_W-1:0]   p_pri;
    logic [ID_BITS-1:0] n_id;
    logic [PRI_W-1:0]   n_pri;

    assign valid = size > CNT_W'(i);

    if (i == 0) begin : g_first
      assign p_ge  = 1'b1;
      assign p_id  = '0;
      assign p_pri = '0;
    end else begin : g_mid
      assign p_ge  = ge_w[i-1];
      assign p_id  = id_w[i-1];
      assign p_pri = pri_w[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign n_id  = '0;
      assign n_pri = '0;
    end else begin : g_body
      assign n_id  = id_w[i+1];
      assign n_pri = pri_w[i+1];
    end

    prq_cell #(.ID_BITS(ID_BITS)) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .new_id   (new_id),
      .valid    (valid),
      .prev_ge  (p_ge),
      .prev_id  (p_id),
      .prev_pri (p_pri),
      .next_id  (n_id),
      .next_pri (n_pri),
      .ge       (ge_w[i]),
      .id       (id_w[i]),
      .pri      (pri_w[i])
    );
  end

  assign front_id  = id_w[0];
  assign front_pri = pri_w[0];

endmodule

@@ rtl/priority_ready_queue_scheduler.sv @@
// Strict-priority scheduler with one priority-ordered ready queue, first-in-first-out within a priority.
// Top level: request handling, running thread, slice counter, config, output.
// Depends on prq_pkg and prq_chain.
//
// A tick, an unblock, a set-priority that does not dispatch, or an unknown code
// is done on acceptance; a yield, a block or a dispatching set-priority also goes
// through the dispatch state: any re-queue of the running thread goes into the cell
// chain on the accept cycle, and the front is popped into the running thread in the
// following cycle. The chain shifts all slots in parallel, so handling does not
// depend on the queue fill. One request is in flight at a time; the result sits in
// an output register and the next request is taken as soon as that register can be freed.
module priority_ready_queue_scheduler
  import prq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64,
  parameter int ID_BITS     = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_addr,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic                s_tvalid,
  output logic                s_tready,
  // req_type[2:0]
  input  logic [REQ_W-1:0]    s_tuser,
  // thread_id[ID_BITS], priority_req[6], zero pad
  input  logic [((ID_BITS + PRI_W + 7) / 8) * 8 - 1:0] s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  // running_id[ID_BITS], running_priority[6], ready_count[CNT_W],
  // preempt_request, switched, overflow, zero pad
  output logic [((ID_BITS + PRI_W + $clog2(QUEUE_DEPTH + 1) + 3 + 7) / 8) * 8 - 1:0] m_tdata
);

  localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int IN_W     = ID_BITS + PRI_W;
  localparam int OUT_W    = ID_BITS + PRI_W + CNT_W + 3;
  localparam int OUT_TD_W = ((OUT_W + 7) / 8) * 8;

  logic [REQ_W-1:0]   in_req;
  logic [ID_BITS-1:0] in_id;
  logic [PRI_W-1:0]   in_pri;

  assign in_req = s_tuser;
  assign in_id  = s_tdata[ID_BITS-1:0];
  assign in_pri = s_tdata[IN_W-1:ID_BITS];

  state_t             state, state_next;
  logic [CFG_W-1:0]   slice_limit;
  logic [CFG_W-1:0]   idle_reg;
  logic [ID_BITS-1:0] cur_id, cur_id_next;
  logic [PRI_W-1:0]   cur_pri, cur_pri_next;
  logic [CNT_W-1:0]   size, size_next;
  logic [CFG_W-1:0]   slice, slice_next;
  logic               ovf_pend, ovf_pend_next;
  logic               out_valid_next;
  logic [ID_BITS-1:0] out_id;
  logic [PRI_W-1:0]   out_pri;
  logic [CNT_W-1:0]   out_cnt;
  logic               out_pre, out_sw, out_ovf;
  logic               out_pre_next, out_sw_next, out_ovf_next;
  logic               out_load;

  chain_ctrl_t        ctrl;
  logic [ID_BITS-1:0] chain_id;
  logic [ID_BITS-1:0] front_id;
  logic [PRI_W-1:0]   front_pri;

  logic [ID_BITS-1:0] idle_id;
  logic               full;
  logic               accept;

  assign idle_id  = ID_BITS'(idle_reg);
  assign full     = size == CNT_W'(QUEUE_DEPTH);
  assign s_tready = (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  prq_chain #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS),
    .CNT_W       (CNT_W)
  ) u_chain (
    .clk       (clk),
    .ctrl      (ctrl),
    .new_id    (chain_id),
    .size      (size),
    .front_id  (front_id),
    .front_pri (front_pri)
  );

  always_comb begin
    state_next     = state;
    cur_id_next    = cur_id;
    cur_pri_next   = cur_pri;
    size_next      = size;
    slice_next     = slice;
    ovf_pend_next  = ovf_pend;
    out_valid_next = m_tvalid && !m_tready;
    out_load       = 1'b0;
    out_pre_next   = 1'b0;
    out_sw_next    = 1'b0;
    out_ovf_next   = 1'b0;
    ctrl.op        = OP_NONE;
    ctrl.pri       = in_pri;
    chain_id       = in_id;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          ovf_pend_next = 1'b0;
          unique case (in_req)
            REQ_TICK: begin
              if (slice != SLICE_MAX) begin
                slice_next = slice + 1'b1;
              end
              out_pre_next = slice_next >= slice_limit;
              out_load     = 1'b1;
            end
            REQ_UNBLOCK: begin
              if (full) begin
                out_ovf_next = 1'b1;
              end else begin
                ctrl.op   = OP_INSERT;
                size_next = size + 1'b1;
              end
              out_load = 1'b1;
            end
            REQ_YIELD, REQ_BLOCK, REQ_SETPRI: begin
              if (in_req == REQ_SETPRI) begin
                cur_pri_next = in_pri;
              end
              if (in_req == REQ_SETPRI && !(size != '0 && front_pri > in_pri)) begin
                out_load = 1'b1;
              end else begin
                state_next = ST_DISPATCH;
                if (in_req != REQ_BLOCK && cur_id != idle_id) begin
                  chain_id = cur_id;
                  ctrl.pri = cur_pri_next;
                  if (full) begin
                    ovf_pend_next = 1'b1;
                  end else begin
                    ctrl.op   = OP_INSERT;
                    size_next = size + 1'b1;
                  end
                end
              end
            end
            default: out_load = 1'b1;
          endcase
        end
      end
      ST_DISPATCH: begin
        if (size == '0) begin
          cur_id_next  = idle_id;
          cur_pri_next = '0;
        end else begin
          cur_id_next  = front_id;
          cur_pri_next = front_pri;
          size_next    = size - 1'b1;
          ctrl.op      = OP_POP;
        end
        slice_next   = '0;
        out_sw_next  = 1'b1;
        out_ovf_next = ovf_pend;
        out_load     = 1'b1;
        state_next   = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase

    if (out_load) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      slice_limit <= SLICE_LIMIT_RST;
      idle_reg    <= IDLE_ID_RST;
      cur_id      <= ID_BITS'(IDLE_ID_RST);
      cur_pri     <= '0;
      size        <= '0;
      slice       <= '0;
      ovf_pend    <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      state    <= state_next;
      cur_id   <= cur_id_next;
      cur_pri  <= cur_pri_next;
      size     <= size_next;
      slice    <= slice_next;
      ovf_pend <= ovf_pend_next;
      m_tvalid <= out_valid_next;
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_SLICE_LIMIT: slice_limit <= cfg_data;
          CFG_IDLE_ID:     idle_reg    <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_id  <= cur_id_next;
      out_pri <= cur_pri_next;
      out_cnt <= size_next;
      out_pre <= out_pre_next;
      out_sw  <= out_sw_next;
      out_ovf <= out_ovf_next;
    end
  end

  assign m_tdata = OUT_TD_W'({out_ovf, out_sw, out_pre, out_cnt, out_pri, out_id});

endmodule
